### sv/pwmt_pkg.sv
`timescale 1ns / 1ps

package pwmt_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Register indexes
    localparam logic [3:0] REG_CTRL     = 4'd0;
    localparam logic [3:0] REG_STATUS   = 4'd1;
    localparam logic [3:0] REG_EVENT    = 4'd2;
    localparam logic [3:0] REG_MODE     = 4'd3;
    localparam logic [3:0] REG_CHAN     = 4'd4;
    localparam logic [3:0] REG_COUNT    = 4'd5;
    localparam logic [3:0] REG_PRESCALE = 4'd6;
    localparam logic [3:0] REG_RELOAD   = 4'd7;
    localparam logic [3:0] REG_COMPARE  = 4'd8;
    localparam logic [3:0] REG_OUTEN    = 4'd9;

    // Output compare modes
    localparam logic [2:0] MODE_PWM1 = 3'b110;
    localparam logic [2:0] MODE_PWM2 = 3'b111;

    // Bit positions inside registers
    localparam int CTRL_BUF_BIT  = 7;
    localparam int MODE_BUF_BIT  = 3;
    localparam int MODE_LSB      = 4;
    localparam int OUTEN_BIT     = 15;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  reg_select;
        logic [15:0] write_data;
    } cmd_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        pwm_level;
        logic        update_pending;
    } rsp_t;

    // Pipeline control between the input stage and the rest
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } stage_t;

endpackage

### sv/pwmt_ifs.sv
`timescale 1ns / 1ps

// Command channel: one tick, register write or register read per item
interface pwmt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  reg_select;
    logic [15:0] write_data;

    modport source (output valid, kind, reg_select, write_data, input ready);
    modport sink   (input valid, kind, reg_select, write_data, output ready);
endinterface

// Response channel: one result item per command item
interface pwmt_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        pwm_level;
    logic        update_pending;

    modport source (output valid, read_data, pwm_level, update_pending, input ready);
    modport sink   (input valid, read_data, pwm_level, update_pending, output ready);
endinterface

### sv/pwm_timer_with_prescaler_core.sv
`timescale 1ns / 1ps

// Up-counting timer with prescaler, buffered reload/compare and one PWM output.
// cmd channel: each item is a tick (kind 0), a register write (kind 1) or a
// register read (kind 2), with reg_select and write_data.
// rsp channel: exactly one item per cmd item, in order: read_data (zero
// unless a read), pwm_level and update_pending as they stand after the item.
// An accepted item passes the input register, then the state update into the
// result register, before its result shows on rsp.
// Throughput: one item per cycle while rsp does not stall; all state updates for
// an item settle in combinational logic between the input and result registers.
// Reset (rst_n low, asynchronous) returns all state registers to their reset
// values: counter off, reload all ones, everything else zero. No clear pass.
// When rsp stalls, the result register holds and the input register still
// takes one more item; cmd.ready drops only when both are full.
// COUNT_WIDTH (8 to 32) sets the width of count, reload and compare; reads
// return their low 16 bits.
module pwm_timer_with_prescaler_core
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    pwmt_cmd_if.sink          cmd,
    pwmt_rsp_if.source        rsp
);

    pwmt_pkg::cmd_t   cmd_in;
    pwmt_pkg::stage_t stage;
    pwmt_pkg::rsp_t   core_rsp;
    pwmt_pkg::rsp_t   out_rsp;
    logic             advance;
    logic             apply;

    assign cmd_in.kind       = cmd.kind;
    assign cmd_in.reg_select = cmd.reg_select;
    assign cmd_in.write_data = cmd.write_data;

    // Item is applied when its result has room to land
    assign apply = stage.valid && advance;

    pwmt_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .in_cmd   (cmd_in),
        .stage    (stage)
    );

    pwmt_state #(.COUNT_WIDTH(COUNT_WIDTH)) u_state
    (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (apply),
        .cmd   (stage.cmd),
        .rsp   (core_rsp)
    );

    pwmt_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (stage.valid),
        .load_rsp   (core_rsp),
        .advance    (advance),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_rsp    (out_rsp)
    );

    assign rsp.read_data      = out_rsp.read_data;
    assign rsp.pwm_level      = out_rsp.pwm_level;
    assign rsp.update_pending = out_rsp.update_pending;

endmodule

### sv/pwmt_in_stage.sv
`timescale 1ns / 1ps

// Input register: holds one command item until the core can apply it
module pwmt_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    output logic              in_ready,
    input  pwmt_pkg::cmd_t    in_cmd,
    output pwmt_pkg::stage_t  stage
);

    logic           valid_reg;
    logic           valid_next;
    pwmt_pkg::cmd_t cmd_reg;

    // Slot frees up whenever its item moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= in_cmd;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.cmd   = cmd_reg;

endmodule

### sv/pwmt_state.sv
`timescale 1ns / 1ps

// Timer state, register file and output level; applies one item per cycle while apply is high
module pwmt_state
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             apply,
    input  pwmt_pkg::cmd_t   cmd,
    output pwmt_pkg::rsp_t   rsp
);

    logic                   counter_enable_reg, counter_enable_next;
    logic                   reload_buffered_reg, reload_buffered_next;
    logic [15:0]            prescale_written_reg, prescale_written_next;
    logic [15:0]            prescale_active_reg, prescale_active_next;
    logic [15:0]            prescale_count_reg, prescale_count_next;
    logic [COUNT_WIDTH-1:0] main_count_reg, main_count_next;
    logic [COUNT_WIDTH-1:0] reload_written_reg, reload_written_next;
    logic [COUNT_WIDTH-1:0] reload_active_reg, reload_active_next;
    logic [COUNT_WIDTH-1:0] compare_written_reg, compare_written_next;
    logic [COUNT_WIDTH-1:0] compare_active_reg, compare_active_next;
    logic [2:0]             output_mode_reg, output_mode_next;
    logic                   compare_buffered_reg, compare_buffered_next;
    logic                   channel_on_reg, channel_on_next;
    logic                   polarity_low_reg, polarity_low_next;
    logic                   outputs_on_reg, outputs_on_next;
    logic                   update_flag_reg, update_flag_next;

    logic                   do_update;
    logic [15:0]            read_value;
    logic [31:0]            wdata_ext;
    logic [COUNT_WIDTH-1:0] wdata_cnt;
    logic [31:0]            count_ext;
    logic [31:0]            reload_ext;
    logic [31:0]            compare_ext;
    logic                   ref_level;

    assign wdata_ext   = 32'(cmd.write_data);
    assign wdata_cnt   = wdata_ext[COUNT_WIDTH-1:0];
    assign count_ext   = 32'(main_count_reg);
    assign reload_ext  = 32'(reload_written_reg);
    assign compare_ext = 32'(compare_written_reg);

    // Next state: tick, write or read, then the update event copies
    always_comb
    begin
        counter_enable_next   = counter_enable_reg;
        reload_buffered_next  = reload_buffered_reg;
        prescale_written_next = prescale_written_reg;
        prescale_active_next  = prescale_active_reg;
        prescale_count_next   = prescale_count_reg;
        main_count_next       = main_count_reg;
        reload_written_next   = reload_written_reg;
        reload_active_next    = reload_active_reg;
        compare_written_next  = compare_written_reg;
        compare_active_next   = compare_active_reg;
        output_mode_next      = output_mode_reg;
        compare_buffered_next = compare_buffered_reg;
        channel_on_next       = channel_on_reg;
        polarity_low_next     = polarity_low_reg;
        outputs_on_next       = outputs_on_reg;
        update_flag_next      = update_flag_reg;
        do_update             = 1'b0;
        read_value            = 16'd0;

        if (apply)
        begin
            case (cmd.kind)
                pwmt_pkg::KIND_TICK:
                begin
                    if (counter_enable_reg)
                    begin
                        if (prescale_count_reg >= prescale_active_reg)
                        begin
                            prescale_count_next = 16'd0;
                            if (main_count_reg == reload_active_reg)
                            begin
                                main_count_next = '0;
                                do_update       = 1'b1;
                            end
                            else
                            begin
                                main_count_next = main_count_reg
                                    + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                            end
                        end
                        else
                        begin
                            prescale_count_next = prescale_count_reg + 16'd1;
                        end
                    end
                end
                pwmt_pkg::KIND_WRITE:
                begin
                    case (cmd.reg_select)
                        pwmt_pkg::REG_CTRL:
                        begin
                            counter_enable_next  = cmd.write_data[0];
                            reload_buffered_next = cmd.write_data[pwmt_pkg::CTRL_BUF_BIT];
                        end
                        pwmt_pkg::REG_STATUS:
                        begin
                            if (!cmd.write_data[0])
                            begin
                                update_flag_next = 1'b0;
                            end
                        end
                        pwmt_pkg::REG_EVENT:
                        begin
                            if (cmd.write_data[0])
                            begin
                                main_count_next     = '0;
                                prescale_count_next = 16'd0;
                                do_update           = 1'b1;
                            end
                        end
                        pwmt_pkg::REG_MODE:
                        begin
                            output_mode_next =
                                cmd.write_data[pwmt_pkg::MODE_LSB +: 3];
                            compare_buffered_next =
                                cmd.write_data[pwmt_pkg::MODE_BUF_BIT];
                        end
                        pwmt_pkg::REG_CHAN:
                        begin
                            channel_on_next   = cmd.write_data[0];
                            polarity_low_next = cmd.write_data[1];
                        end
                        pwmt_pkg::REG_COUNT:
                        begin
                            main_count_next = wdata_cnt;
                        end
                        pwmt_pkg::REG_PRESCALE:
                        begin
                            prescale_written_next = cmd.write_data;
                        end
                        pwmt_pkg::REG_RELOAD:
                        begin
                            reload_written_next = wdata_cnt;
                            if (!reload_buffered_reg)
                            begin
                                reload_active_next = wdata_cnt;
                            end
                        end
                        pwmt_pkg::REG_COMPARE:
                        begin
                            compare_written_next = wdata_cnt;
                            if (!compare_buffered_reg)
                            begin
                                compare_active_next = wdata_cnt;
                            end
                        end
                        pwmt_pkg::REG_OUTEN:
                        begin
                            outputs_on_next = cmd.write_data[pwmt_pkg::OUTEN_BIT];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                pwmt_pkg::KIND_READ:
                begin
                    case (cmd.reg_select)
                        pwmt_pkg::REG_CTRL:
                            read_value = {8'd0, reload_buffered_reg, 6'd0,
                                          counter_enable_reg};
                        pwmt_pkg::REG_STATUS:
                            read_value = {15'd0, update_flag_reg};
                        pwmt_pkg::REG_MODE:
                            read_value = {9'd0, output_mode_reg, compare_buffered_reg,
                                          3'd0};
                        pwmt_pkg::REG_CHAN:
                            read_value = {14'd0, polarity_low_reg, channel_on_reg};
                        pwmt_pkg::REG_COUNT:
                            read_value = count_ext[15:0];
                        pwmt_pkg::REG_PRESCALE:
                            read_value = prescale_written_reg;
                        pwmt_pkg::REG_RELOAD:
                            read_value = reload_ext[15:0];
                        pwmt_pkg::REG_COMPARE:
                            read_value = compare_ext[15:0];
                        pwmt_pkg::REG_OUTEN:
                            read_value = {outputs_on_reg, 15'd0};
                        default:
                            read_value = 16'd0;
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        // Update event: latch shadow copies and raise the flag
        if (do_update)
        begin
            prescale_active_next = prescale_written_reg;
            if (reload_buffered_reg)
            begin
                reload_active_next = reload_written_reg;
            end
            if (compare_buffered_reg)
            begin
                compare_active_next = compare_written_reg;
            end
            update_flag_next = 1'b1;
        end
    end

    // Output level from the state after this item
    always_comb
    begin
        case (output_mode_next)
            pwmt_pkg::MODE_PWM1: ref_level = (main_count_next < compare_active_next);
            pwmt_pkg::MODE_PWM2: ref_level = (main_count_next >= compare_active_next);
            default:             ref_level = 1'b0;
        endcase
    end

    assign rsp.read_data      = read_value;
    assign rsp.pwm_level      = channel_on_next && outputs_on_next
                                && (ref_level ^ polarity_low_next);
    assign rsp.update_pending = update_flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_enable_reg   <= 1'b0;
            reload_buffered_reg  <= 1'b0;
            prescale_written_reg <= 16'd0;
            prescale_active_reg  <= 16'd0;
            prescale_count_reg   <= 16'd0;
            main_count_reg       <= '0;
            reload_written_reg   <= '1;
            reload_active_reg    <= '1;
            compare_written_reg  <= '0;
            compare_active_reg   <= '0;
            output_mode_reg      <= 3'd0;
            compare_buffered_reg <= 1'b0;
            channel_on_reg       <= 1'b0;
            polarity_low_reg     <= 1'b0;
            outputs_on_reg       <= 1'b0;
            update_flag_reg      <= 1'b0;
        end
        else
        begin
            counter_enable_reg   <= counter_enable_next;
            reload_buffered_reg  <= reload_buffered_next;
            prescale_written_reg <= prescale_written_next;
            prescale_active_reg  <= prescale_active_next;
            prescale_count_reg   <= prescale_count_next;
            main_count_reg       <= main_count_next;
            reload_written_reg   <= reload_written_next;
            reload_active_reg    <= reload_active_next;
            compare_written_reg  <= compare_written_next;
            compare_active_reg   <= compare_active_next;
            output_mode_reg      <= output_mode_next;
            compare_buffered_reg <= compare_buffered_next;
            channel_on_reg       <= channel_on_next;
            polarity_low_reg     <= polarity_low_next;
            outputs_on_reg       <= outputs_on_next;
            update_flag_reg      <= update_flag_next;
        end
    end

    // The flag only drops through a status write
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(update_flag_reg) |->
            $past(apply && cmd.kind == pwmt_pkg::KIND_WRITE
                  && cmd.reg_select == pwmt_pkg::REG_STATUS))
        else $error("update flag cleared without a status write");

    // Nothing changes the count without an applied item
    assert property (@(posedge clk) disable iff (!rst_n)
        !apply |=> $stable(main_count_reg) && $stable(prescale_count_reg))
        else $error("count moved with no item applied");

    // A forced update zeroes both counters and sets the flag
    assert property (@(posedge clk) disable iff (!rst_n)
        apply && cmd.kind == pwmt_pkg::KIND_WRITE
            && cmd.reg_select == pwmt_pkg::REG_EVENT && cmd.write_data[0]
        |=> main_count_reg == '0 && prescale_count_reg == 16'd0 && update_flag_reg)
        else $error("forced update did not restart the counter");

    // Read data is zero for anything but a read
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.read_data != 16'd0 |-> apply && cmd.kind == pwmt_pkg::KIND_READ)
        else $error("read data driven on a non-read item");

endmodule

### sv/pwmt_out_stage.sv
`timescale 1ns / 1ps

// Result register: holds one result item until the receiver takes it
module pwmt_out_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load_valid,
    input  pwmt_pkg::rsp_t  load_rsp,
    output logic            advance,
    output logic            out_valid,
    input  logic            out_ready,
    output pwmt_pkg::rsp_t  out_rsp
);

    logic           valid_reg;
    logic           valid_next;
    pwmt_pkg::rsp_t rsp_reg;

    // Register may reload when empty or being emptied this cycle
    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            rsp_reg <= load_rsp;
        end
    end

    assign out_valid = valid_reg;
    assign out_rsp   = rsp_reg;

endmodule

### tb/pwm_timer_with_prescaler_core_tb.sv
`timescale 1ns / 1ps

module pwm_timer_with_prescaler_core_tb;

    localparam int CNT_W      = 16;
    localparam int N_RANDOM   = 600;
    localparam int DRAIN_AT   = 300;
    localparam int MAX_CYCLES = 200000;
    localparam int N_DIR      = 27;

    // Codes the block has no meaning for
    localparam logic [1:0] KIND_NONE     = 2'd3;
    localparam logic [3:0] REG_UNUSED    = 4'hC;
    localparam logic [3:0] REG_UNUSED_HI = 4'hF;

    localparam logic           TYPED     = 1'b1;
    localparam logic           PREDICTED = 1'b0;
    localparam pwmt_pkg::rsp_t NO_RSP    = '0;

    typedef struct packed {
        pwmt_pkg::cmd_t cmd;
        logic           typed;
        pwmt_pkg::rsp_t rsp;
    } dir_row_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           steady;
    int             mismatches = 0;
    int             cycle_cnt = 0;
    pwmt_pkg::rsp_t want;

    pwmt_pkg::rsp_t timer_results_q [$];
    dir_row_t       dir_tab [N_DIR];

    // Predicted timer state, reset values
    logic             tmr_run    = 1'b0;
    logic             arr_buf    = 1'b0;
    logic [15:0]      psc_shadow = '0;
    logic [15:0]      psc_live   = '0;
    logic [15:0]      psc_cnt    = '0;
    logic [CNT_W-1:0] cnt        = '0;
    logic [CNT_W-1:0] arr_shadow = '1;
    logic [CNT_W-1:0] arr_live   = '1;
    logic [CNT_W-1:0] ccr_shadow = '0;
    logic [CNT_W-1:0] ccr_live   = '0;
    logic [2:0]       oc_mode    = '0;
    logic             ccr_buf    = 1'b0;
    logic             ch_en      = 1'b0;
    logic             ch_inv     = 1'b0;
    logic             moe        = 1'b0;
    logic             uif        = 1'b0;

    pwmt_cmd_if cmd_ch ();
    pwmt_rsp_if rsp_ch ();

    pwm_timer_with_prescaler_core #(
        .COUNT_WIDTH (CNT_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Update event: load shadows into live copies, raise the flag
    function automatic void timer_update();
        psc_live = psc_shadow;
        if (arr_buf)
        begin
            arr_live = arr_shadow;
        end
        if (ccr_buf)
        begin
            ccr_live = ccr_shadow;
        end
        uif = 1'b1;
    endfunction

    // Apply one item to the predicted state and return its result
    function automatic pwmt_pkg::rsp_t timer_step(input pwmt_pkg::cmd_t c);
        pwmt_pkg::rsp_t r;
        logic           lvl;
        logic [15:0]    d;
        r = '0;
        d = c.write_data;
        case (c.kind)
            pwmt_pkg::KIND_TICK:
            begin
                if (tmr_run)
                begin
                    if (psc_cnt >= psc_live)
                    begin
                        psc_cnt = '0;
                        if (cnt == arr_live)
                        begin
                            cnt = '0;
                            timer_update();
                        end
                        else
                        begin
                            cnt = cnt + 1'b1;
                        end
                    end
                    else
                    begin
                        psc_cnt = psc_cnt + 1'b1;
                    end
                end
            end
            pwmt_pkg::KIND_WRITE:
            begin
                case (c.reg_select)
                    pwmt_pkg::REG_CTRL:
                    begin
                        tmr_run = d[0];
                        arr_buf = d[pwmt_pkg::CTRL_BUF_BIT];
                    end
                    pwmt_pkg::REG_STATUS:
                    begin
                        if (!d[0])
                        begin
                            uif = 1'b0;
                        end
                    end
                    pwmt_pkg::REG_EVENT:
                    begin
                        if (d[0])
                        begin
                            cnt = '0;
                            psc_cnt = '0;
                            timer_update();
                        end
                    end
                    pwmt_pkg::REG_MODE:
                    begin
                        oc_mode = d[pwmt_pkg::MODE_LSB +: 3];
                        ccr_buf = d[pwmt_pkg::MODE_BUF_BIT];
                    end
                    pwmt_pkg::REG_CHAN:
                    begin
                        ch_en  = d[0];
                        ch_inv = d[1];
                    end
                    pwmt_pkg::REG_COUNT:    cnt = d;
                    pwmt_pkg::REG_PRESCALE: psc_shadow = d;
                    pwmt_pkg::REG_RELOAD:
                    begin
                        arr_shadow = d;
                        if (!arr_buf)
                        begin
                            arr_live = d;
                        end
                    end
                    pwmt_pkg::REG_COMPARE:
                    begin
                        ccr_shadow = d;
                        if (!ccr_buf)
                        begin
                            ccr_live = d;
                        end
                    end
                    pwmt_pkg::REG_OUTEN:    moe = d[pwmt_pkg::OUTEN_BIT];
                    default: ;
                endcase
            end
            pwmt_pkg::KIND_READ:
            begin
                case (c.reg_select)
                    pwmt_pkg::REG_CTRL:
                    begin
                        r.read_data[0]                      = tmr_run;
                        r.read_data[pwmt_pkg::CTRL_BUF_BIT] = arr_buf;
                    end
                    pwmt_pkg::REG_STATUS:   r.read_data[0] = uif;
                    pwmt_pkg::REG_MODE:
                    begin
                        r.read_data[pwmt_pkg::MODE_LSB +: 3] = oc_mode;
                        r.read_data[pwmt_pkg::MODE_BUF_BIT]  = ccr_buf;
                    end
                    pwmt_pkg::REG_CHAN:
                    begin
                        r.read_data[0] = ch_en;
                        r.read_data[1] = ch_inv;
                    end
                    pwmt_pkg::REG_COUNT:    r.read_data = cnt;
                    pwmt_pkg::REG_PRESCALE: r.read_data = psc_shadow;
                    pwmt_pkg::REG_RELOAD:   r.read_data = arr_shadow;
                    pwmt_pkg::REG_COMPARE:  r.read_data = ccr_shadow;
                    pwmt_pkg::REG_OUTEN:    r.read_data[pwmt_pkg::OUTEN_BIT] = moe;
                    default: ;
                endcase
            end
            default: ;
        endcase

        // PWM1 active below compare, PWM2 at or above, anything else inactive
        lvl = 1'b0;
        if (oc_mode == pwmt_pkg::MODE_PWM1)
        begin
            lvl = (cnt < ccr_live);
        end
        else if (oc_mode == pwmt_pkg::MODE_PWM2)
        begin
            lvl = (cnt >= ccr_live);
        end
        r.pwm_level      = (ch_en && moe) ? (lvl ^ ch_inv) : 1'b0;
        r.update_pending = uif;
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
        begin
            return 0;
        end
        if (p < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Drive one item from the falling edge, hold until accepted
    task automatic send_item(input pwmt_pkg::cmd_t c, input int gap, input logic typed,
                             input pwmt_pkg::rsp_t typed_rsp);
        pwmt_pkg::rsp_t predicted;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= c.kind;
        cmd_ch.reg_select <= c.reg_select;
        cmd_ch.write_data <= c.write_data;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = timer_step(c);
        timer_results_q.push_back(typed ? typed_rsp : predicted);
    endtask

    // Result side: random stalls, none while steady
    initial
    begin
        int hold;
        rsp_ch.ready = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0 && !steady)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                hold = (!steady && $urandom_range(0, 5) == 0) ? pick_gap() : 0;
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (timer_results_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: read_data %h pwm %b upd %b",
                         $time, rsp_ch.read_data, rsp_ch.pwm_level, rsp_ch.update_pending);
                mismatches++;
            end
            else
            begin
                want = timer_results_q.pop_front();
                if (rsp_ch.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h, got %h",
                             $time, want.read_data, rsp_ch.read_data);
                    mismatches++;
                end
                if (rsp_ch.pwm_level !== want.pwm_level)
                begin
                    $display("%0t: pwm_level expected %b, got %b",
                             $time, want.pwm_level, rsp_ch.pwm_level);
                    mismatches++;
                end
                if (rsp_ch.update_pending !== want.update_pending)
                begin
                    $display("%0t: update_pending expected %b, got %b",
                             $time, want.update_pending, rsp_ch.update_pending);
                    mismatches++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= MAX_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        pwmt_pkg::cmd_t c;
        int             n_real;
        int             pick;
        int             gap;
        logic           noise;

        rst_n             = 1'b0;
        steady            = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.kind       = pwmt_pkg::KIND_TICK;
        cmd_ch.reg_select = pwmt_pkg::REG_CTRL;
        cmd_ch.write_data = '0;

        // Directed: reset values, ignored codes, a full PWM period with
        // wrap, status clear/keep, buffered compare, polarity, count wrap
        dir_tab = '{
            {pwmt_pkg::KIND_READ,  pwmt_pkg::REG_RELOAD,   16'h0000, TYPED,
             16'hFFFF, 1'b0, 1'b0},
            {pwmt_pkg::KIND_READ,  pwmt_pkg::REG_COUNT,    16'hFFFF, TYPED,
             16'h0000, 1'b0, 1'b0},
            {pwmt_pkg::KIND_READ,  REG_UNUSED_HI,          16'h0000, TYPED,
             16'h0000, 1'b0, 1'b0},
            {KIND_NONE,            pwmt_pkg::REG_CTRL,     16'hFFFF, TYPED,
             16'h0000, 1'b0, 1'b0},
            {pwmt_pkg::KIND_WRITE, REG_UNUSED,             16'hFFFF, TYPED,
             16'h0000, 1'b0, 1'b0},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_PRESCALE, 16'h0001, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_RELOAD,   16'h0002, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_COMPARE,  16'h0002, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_MODE,     16'h0060, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_CHAN,     16'h0001, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_OUTEN,    16'h8000, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_EVENT,    16'h0001, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_CTRL,     16'h0081, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_TICK,  pwmt_pkg::REG_CTRL,     16'h0000, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_TICK,  pwmt_pkg::REG_CTRL,     16'h0000, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_TICK,  pwmt_pkg::REG_CTRL,     16'h0000, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_TICK,  pwmt_pkg::REG_CTRL,     16'h0000, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_TICK,  pwmt_pkg::REG_CTRL,     16'h0000, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_TICK,  pwmt_pkg::REG_CTRL,     16'h0000, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_STATUS,   16'h0001, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_STATUS,   16'hFFFE, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_MODE,     16'h0078, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_COMPARE,  16'hFFFF, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_CHAN,     16'h0003, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_WRITE, pwmt_pkg::REG_COUNT,    16'hFFFF, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_TICK,  pwmt_pkg::REG_CTRL,     16'h0000, PREDICTED, NO_RSP},
            {pwmt_pkg::KIND_TICK,  pwmt_pkg::REG_CTRL,     16'h0000, PREDICTED, NO_RSP}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            send_item(dir_tab[i].cmd, pick_gap(), dir_tab[i].typed, dir_tab[i].rsp);
        end

        // Random: mostly ticks, writes biased to short periods so the
        // counter wraps often, some reads, a little noise
        n_real = 0;
        while (n_real < N_RANDOM)
        begin
            steady       = (n_real >= 150 && n_real < 260);
            noise        = 1'b0;
            c.kind       = pwmt_pkg::KIND_TICK;
            c.reg_select = 4'($urandom);
            c.write_data = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick >= 60 && pick < 86)
            begin
                c.kind       = pwmt_pkg::KIND_WRITE;
                c.reg_select = 4'($urandom_range(0, 9));
                case (c.reg_select)
                    pwmt_pkg::REG_CTRL:  c.write_data[0] = ($urandom_range(0, 99) < 85);
                    pwmt_pkg::REG_EVENT: c.write_data[0] = ($urandom_range(0, 3) == 0);
                    pwmt_pkg::REG_MODE:
                    begin
                        if ($urandom_range(0, 9) < 7)
                        begin
                            c.write_data[pwmt_pkg::MODE_LSB +: 3] =
                                $urandom_range(0, 1) ? pwmt_pkg::MODE_PWM2
                                                     : pwmt_pkg::MODE_PWM1;
                        end
                    end
                    pwmt_pkg::REG_CHAN:  c.write_data[0] = ($urandom_range(0, 99) < 80);
                    pwmt_pkg::REG_OUTEN:
                        c.write_data[pwmt_pkg::OUTEN_BIT] = ($urandom_range(0, 99) < 80);
                    pwmt_pkg::REG_COUNT:
                    begin
                        if ($urandom_range(0, 9) < 7)
                        begin
                            c.write_data = 16'($urandom_range(0, 15));
                        end
                    end
                    pwmt_pkg::REG_PRESCALE:
                    begin
                        if ($urandom_range(0, 9) < 8)
                        begin
                            c.write_data = 16'($urandom_range(0, 3));
                        end
                    end
                    pwmt_pkg::REG_RELOAD:
                    begin
                        if ($urandom_range(0, 9) < 8)
                        begin
                            c.write_data = 16'($urandom_range(0, 20));
                        end
                    end
                    pwmt_pkg::REG_COMPARE:
                    begin
                        if ($urandom_range(0, 9) < 8)
                        begin
                            c.write_data = 16'($urandom_range(0, 24));
                        end
                    end
                    default: ;
                endcase
            end
            else if (pick >= 86 && pick < 97)
            begin
                c.kind       = pwmt_pkg::KIND_READ;
                c.reg_select = 4'($urandom_range(0, 9));
            end
            else if (pick >= 97)
            begin
                noise = 1'b1;
                if ($urandom_range(0, 1))
                begin
                    c.kind = KIND_NONE;
                end
                else
                begin
                    c.kind       = $urandom_range(0, 1) ? pwmt_pkg::KIND_WRITE
                                                        : pwmt_pkg::KIND_READ;
                    c.reg_select = 4'($urandom_range(10, 15));
                end
            end

            // Hold off once until every outstanding result is back
            if (n_real == DRAIN_AT && !noise)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
                while (timer_results_q.size() != 0)
                begin
                    @(negedge clk);
                end
            end

            gap = steady ? 0 : pick_gap();
            send_item(c, gap, PREDICTED, NO_RSP);
            if (!noise)
            begin
                n_real++;
            end
        end
        steady = 1'b0;

        @(negedge clk);
        cmd_ch.valid <= 1'b0;

        // Drain, then wait for anything stray
        while (timer_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/pwmt_pkg.sv
sv/pwmt_ifs.sv
sv/pwmt_in_stage.sv
sv/pwmt_state.sv
sv/pwmt_out_stage.sv
sv/pwm_timer_with_prescaler_core.sv
tb/pwm_timer_with_prescaler_core_tb.sv
